// ===== src/tpd_pkg.sv =====
package tpd_pkg;

    localparam int AREA_BITS = 48;

    localparam logic signed [AREA_BITS-1:0] AREA_MAX = {1'b0, {(AREA_BITS-1){1'b1}}};
    localparam logic signed [AREA_BITS-1:0] AREA_MIN = {1'b1, {(AREA_BITS-1){1'b0}}};

endpackage

// ===== src/tpd_track.sv =====
module tpd_track #(
    parameter int INDEX_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  last_sample,
    input  logic signed [SAMPLE_BITS-1:0]         threshold,
    output logic                                  emit,
    output logic        [INDEX_BITS-1:0]          left_index,
    output logic signed [SAMPLE_BITS-1:0]         left_value,
    output logic        [INDEX_BITS-1:0]          peak_index,
    output logic signed [SAMPLE_BITS-1:0]         peak_value,
    output logic        [INDEX_BITS-1:0]          right_index,
    output logic signed [SAMPLE_BITS-1:0]         right_value,
    output logic signed [tpd_pkg::AREA_BITS-1:0]  area_twice
);

    import tpd_pkg::*;

    logic        [INDEX_BITS-1:0]   sample_count_reg, sample_count_next;
    logic                           left_valid_reg, left_valid_next;
    logic        [INDEX_BITS-1:0]   left_pos_reg, left_pos_next;
    logic signed [SAMPLE_BITS-1:0]  left_level_reg, left_level_next;
    logic                           top_valid_reg, top_valid_next;
    logic        [INDEX_BITS-1:0]   top_pos_reg, top_pos_next;
    logic signed [SAMPLE_BITS-1:0]  top_level_reg, top_level_next;
    logic                           right_valid_reg, right_valid_next;
    logic        [INDEX_BITS-1:0]   right_pos_reg, right_pos_next;
    logic signed [SAMPLE_BITS-1:0]  right_level_reg, right_level_next;
    logic signed [AREA_BITS-1:0]    running_area_reg, running_area_next;
    logic signed [AREA_BITS-1:0]    area_at_right_reg, area_at_right_next;
    logic signed [SAMPLE_BITS-1:0]  prior_sample_reg, prior_sample_next;

    logic signed [SAMPLE_BITS:0]    pair_sum;
    logic signed [AREA_BITS:0]      area_sum;
    logic signed [AREA_BITS-1:0]    area_sat;
    logic signed [AREA_BITS-1:0]    area_upd;
    logic                           below;
    logic                           emit_now;

    // Trapezoid step: previous sample plus current sample, saturating at the area limits.
    always_comb
    begin
        pair_sum = (SAMPLE_BITS+1)'(prior_sample_reg) + (SAMPLE_BITS+1)'(sample);
        area_sum = (AREA_BITS+1)'(running_area_reg) + (AREA_BITS+1)'(pair_sum);
        if (area_sum[AREA_BITS] != area_sum[AREA_BITS-1])
        begin
            area_sat = area_sum[AREA_BITS] ? AREA_MIN : AREA_MAX;
        end
        else
        begin
            area_sat = area_sum[AREA_BITS-1:0];
        end
        area_upd = left_valid_reg ? area_sat : running_area_reg;
        below    = sample < threshold;
    end

    always_comb
    begin
        sample_count_next  = sample_count_reg;
        left_valid_next    = left_valid_reg;
        left_pos_next      = left_pos_reg;
        left_level_next    = left_level_reg;
        top_valid_next     = top_valid_reg;
        top_pos_next       = top_pos_reg;
        top_level_next     = top_level_reg;
        right_valid_next   = right_valid_reg;
        right_pos_next     = right_pos_reg;
        right_level_next   = right_level_reg;
        running_area_next  = running_area_reg;
        area_at_right_next = area_at_right_reg;
        prior_sample_next  = prior_sample_reg;
        emit_now           = 1'b0;

        if (accept)
        begin
            running_area_next = area_upd;
            if (below)
            begin
                if (right_valid_reg)
                begin
                    if (sample <= right_level_reg)
                    begin
                        right_pos_next     = sample_count_reg;
                        right_level_next   = sample;
                        area_at_right_next = area_upd;
                    end
                    else
                    begin
                        emit_now = 1'b1;
                    end
                end
                else if (left_valid_reg && top_valid_reg)
                begin
                    right_valid_next   = 1'b1;
                    right_pos_next     = sample_count_reg;
                    right_level_next   = sample;
                    area_at_right_next = area_upd;
                end
                else
                begin
                    left_valid_next   = 1'b1;
                    left_pos_next     = sample_count_reg;
                    left_level_next   = sample;
                    running_area_next = '0;
                end
            end
            else if (left_valid_reg)
            begin
                if (!top_valid_reg || sample >= top_level_reg)
                begin
                    top_valid_next = 1'b1;
                    top_pos_next   = sample_count_reg;
                    top_level_next = sample;
                end
            end
            else if (right_valid_reg)
            begin
                emit_now = 1'b1;
            end
            else
            begin
                left_valid_next   = 1'b1;
                left_pos_next     = sample_count_reg;
                left_level_next   = sample;
                running_area_next = '0;
            end

            if (emit_now || last_sample)
            begin
                left_valid_next  = 1'b0;
                top_valid_next   = 1'b0;
                right_valid_next = 1'b0;
            end

            if (last_sample)
            begin
                sample_count_next = '0;
                prior_sample_next = '0;
            end
            else
            begin
                sample_count_next = sample_count_reg + {{(INDEX_BITS-1){1'b0}}, 1'b1};
                prior_sample_next = sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            left_valid_reg   <= 1'b0;
            top_valid_reg    <= 1'b0;
            right_valid_reg  <= 1'b0;
            prior_sample_reg <= '0;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            left_valid_reg   <= left_valid_next;
            top_valid_reg    <= top_valid_next;
            right_valid_reg  <= right_valid_next;
            prior_sample_reg <= prior_sample_next;
        end
    end

    // Trough, peak and area fields are only read while their valid flag is set.
    always_ff @(posedge clk)
    begin
        left_pos_reg      <= left_pos_next;
        left_level_reg    <= left_level_next;
        top_pos_reg       <= top_pos_next;
        top_level_reg     <= top_level_next;
        right_pos_reg     <= right_pos_next;
        right_level_reg   <= right_level_next;
        running_area_reg  <= running_area_next;
        area_at_right_reg <= area_at_right_next;
    end

    assign emit        = emit_now;
    assign left_index  = left_pos_reg;
    assign left_value  = left_level_reg;
    assign peak_index  = top_pos_reg;
    assign peak_value  = top_level_reg;
    assign right_index = right_pos_reg;
    assign right_value = right_level_reg;
    assign area_twice  = area_at_right_reg;

`ifndef SYNTH
    a_top_needs_left: assert property (@(posedge clk) disable iff (!rst_n)
        top_valid_reg |-> left_valid_reg)
        else $error("Peak is held without a left trough.");

    a_right_needs_top: assert property (@(posedge clk) disable iff (!rst_n)
        right_valid_reg |-> top_valid_reg)
        else $error("Right trough is held without a peak.");

    a_emit_needs_right: assert property (@(posedge clk) disable iff (!rst_n)
        emit_now |-> accept && right_valid_reg)
        else $error("Result produced without an open right trough.");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_sample |=> !left_valid_reg && sample_count_reg == '0)
        else $error("Tracking state not cleared after the last item of a series.");
`endif

endmodule

// ===== src/threshold_peak_detector_top.sv =====
// Threshold peak detector: one signed sample per item, at most one peak result per item.
// A result appears in the output register in the cycle after the item that closes it is accepted.
// Throughput: one item per cycle while out_stall does not hold a pending result; the tracking
// update and the saturating area add are combinational between the registers.
// Reset clears the tracking state, the sample index and the threshold (to zero).
module threshold_peak_detector_top #(
    parameter int INDEX_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic signed [SAMPLE_BITS-1:0]         cfg_write_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  last_sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [INDEX_BITS-1:0]          left_index,
    output logic signed [SAMPLE_BITS-1:0]         left_value,
    output logic        [INDEX_BITS-1:0]          peak_index,
    output logic signed [SAMPLE_BITS-1:0]         peak_value,
    output logic        [INDEX_BITS-1:0]          right_index,
    output logic signed [SAMPLE_BITS-1:0]         right_value,
    output logic signed [tpd_pkg::AREA_BITS-1:0]  area_twice
);

    import tpd_pkg::*;

    logic signed [SAMPLE_BITS-1:0]  threshold_reg;
    logic                           out_valid_reg, out_valid_next;
    logic        [INDEX_BITS-1:0]   left_index_reg;
    logic signed [SAMPLE_BITS-1:0]  left_value_reg;
    logic        [INDEX_BITS-1:0]   peak_index_reg;
    logic signed [SAMPLE_BITS-1:0]  peak_value_reg;
    logic        [INDEX_BITS-1:0]   right_index_reg;
    logic signed [SAMPLE_BITS-1:0]  right_value_reg;
    logic signed [AREA_BITS-1:0]    area_twice_reg;

    logic                           accept;
    logic                           emit;
    logic        [INDEX_BITS-1:0]   trk_left_index;
    logic signed [SAMPLE_BITS-1:0]  trk_left_value;
    logic        [INDEX_BITS-1:0]   trk_peak_index;
    logic signed [SAMPLE_BITS-1:0]  trk_peak_value;
    logic        [INDEX_BITS-1:0]   trk_right_index;
    logic signed [SAMPLE_BITS-1:0]  trk_right_value;
    logic signed [AREA_BITS-1:0]    trk_area_twice;

    // A new item is taken whenever the output register is empty or being emptied.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    tpd_track #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample      (sample),
        .last_sample (last_sample),
        .threshold   (threshold_reg),
        .emit        (emit),
        .left_index  (trk_left_index),
        .left_value  (trk_left_value),
        .peak_index  (trk_peak_index),
        .peak_value  (trk_peak_value),
        .right_index (trk_right_index),
        .right_value (trk_right_value),
        .area_twice  (trk_area_twice)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                threshold_reg <= cfg_write_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            left_index_reg  <= trk_left_index;
            left_value_reg  <= trk_left_value;
            peak_index_reg  <= trk_peak_index;
            peak_value_reg  <= trk_peak_value;
            right_index_reg <= trk_right_index;
            right_value_reg <= trk_right_value;
            area_twice_reg  <= trk_area_twice;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_index  = left_index_reg;
    assign left_value  = left_value_reg;
    assign peak_index  = peak_index_reg;
    assign peak_value  = peak_value_reg;
    assign right_index = right_index_reg;
    assign right_value = right_value_reg;
    assign area_twice  = area_twice_reg;

endmodule
